>>> rtl/leb_pkg.sv
package leb_pkg;

    // Edit keys and the closing character of a line.
    localparam logic [7:0] KEY_BACKSPACE = 8'h2D;
    localparam logic [7:0] KEY_LEFT      = 8'h3C;
    localparam logic [7:0] KEY_RIGHT     = 8'h3E;
    localparam logic [7:0] NEWLINE_CHAR  = 8'h0A;

    // Request types on the input channel.
    localparam logic REQ_KEY   = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    // Operation broadcast to every cell of the row.
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2
    } t_cell_op;

    typedef struct packed {
        t_cell_op   op;
        logic [7:0] key;
    } t_cell_ctl;

endpackage

>>> rtl/line_edit_gap_buffer.sv
// Line editor over a row of CAPACITY character cells that hold the line in
// order, with the cursor kept as a count of the characters before it. A
// keystroke ('-' backspace, '<' left, '>' right, anything else inserted at
// the cursor) is applied to the row and the cursor counts as it is taken;
// an insert or a backspace moves every cell past the cursor one place along
// the row. An end-of-line request streams the line out of the head of the
// row, shifting the row left one place per transfer, then a newline marked
// end_of_line, and no input is taken until the newline is loaded. Inserts
// into a full line are dropped, and dropped_input is then set on every
// result of that line.
module line_edit_gap_buffer #(
    parameter int CAPACITY = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_req_type,
    input  logic [7:0] i_key_code,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_char,
    output logic       o_end_of_line,
    output logic       o_dropped_input
);
    import leb_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W:0] CAP_SUM = (CNT_W + 1)'(CAPACITY);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_FLUSH = 1'b1;

    logic             r_state, n_state;
    logic [CNT_W-1:0] r_before, n_before;
    logic [CNT_W-1:0] r_after, n_after;
    logic [CNT_W-1:0] r_remain, n_remain;
    logic             r_ovf, n_ovf;
    logic             r_out_valid, n_out_valid;
    logic [7:0]       r_out_char, n_out_char;
    logic             r_out_eol, n_out_eol;
    logic             r_out_drop, n_out_drop;

    t_cell_ctl        w_ctl;
    logic [CNT_W-1:0] w_pos;
    logic [7:0]       w_char [CAPACITY];
    logic             w_in_fire;
    logic             w_out_free;
    logic [CNT_W:0]   w_sum;
    logic             w_full;

    assign w_in_fire  = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_sum      = {1'b0, r_before} + {1'b0, r_after};
    assign w_full     = (w_sum >= CAP_SUM);

    // Edit and flush control; drives the row operation for this cycle.
    always_comb begin
        n_state     = r_state;
        n_before    = r_before;
        n_after     = r_after;
        n_remain    = r_remain;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_char  = r_out_char;
        n_out_eol   = r_out_eol;
        n_out_drop  = r_out_drop;
        w_ctl.op    = CELL_HOLD;
        w_ctl.key   = i_key_code;
        w_pos       = r_before;

        case (r_state)
            ST_IDLE: begin
                if (w_in_fire && i_req_type == REQ_FLUSH) begin
                    n_state  = ST_FLUSH;
                    n_remain = w_sum[CNT_W-1:0];
                end else if (w_in_fire) begin
                    case (i_key_code)
                        KEY_BACKSPACE: begin
                            if (r_before != '0) begin
                                w_ctl.op = CELL_REMOVE;
                                w_pos    = r_before - 1'b1;
                                n_before = r_before - 1'b1;
                            end
                        end
                        KEY_LEFT: begin
                            if (r_before != '0) begin
                                n_before = r_before - 1'b1;
                                n_after  = r_after + 1'b1;
                            end
                        end
                        KEY_RIGHT: begin
                            if (r_after != '0) begin
                                n_before = r_before + 1'b1;
                                n_after  = r_after - 1'b1;
                            end
                        end
                        default: begin
                            if (w_full) begin
                                n_ovf = 1'b1;
                            end else begin
                                w_ctl.op = CELL_INSERT;
                                n_before = r_before + 1'b1;
                            end
                        end
                    endcase
                end
            end
            ST_FLUSH: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_drop  = r_ovf;
                    if (r_remain != '0) begin
                        n_out_char = w_char[0];
                        n_out_eol  = 1'b0;
                        n_remain   = r_remain - 1'b1;
                        w_ctl.op   = CELL_REMOVE;
                        w_pos      = '0;
                    end else begin
                        n_out_char = NEWLINE_CHAR;
                        n_out_eol  = 1'b1;
                        n_before   = '0;
                        n_after    = '0;
                        n_ovf      = 1'b0;
                        n_state    = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_before    <= '0;
            r_after     <= '0;
            r_remain    <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_before    <= n_before;
            r_after     <= n_after;
            r_remain    <= n_remain;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        r_out_char <= n_out_char;
        r_out_eol  <= n_out_eol;
        r_out_drop <= n_out_drop;
    end

    // Row of character cells; each takes from its left or right neighbor.
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_row
        logic [7:0] w_left;
        logic [7:0] w_right;
        if (gi == 0) begin : g_head
            assign w_left = i_key_code;
        end else begin : g_mid_l
            assign w_left = w_char[gi-1];
        end
        if (gi == CAPACITY - 1) begin : g_tail
            assign w_right = w_char[gi];
        end else begin : g_mid_r
            assign w_right = w_char[gi+1];
        end
        leb_cell #(
            .CNT_W    (CNT_W),
            .CELL_IDX (gi)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_pos   (w_pos),
            .i_left  (w_left),
            .i_right (w_right),
            .o_char  (w_char[gi])
        );
    end

    assign o_in_ready      = (r_state == ST_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_out_char      = r_out_char;
    assign o_end_of_line   = r_out_eol;
    assign o_dropped_input = r_out_drop;

    // The line never holds more characters than there are cells.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sum <= CAP_SUM)
        else $error("line length exceeds capacity");

    // Loading the closing newline empties the line and clears the drop flag.
    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FLUSH && w_out_free && r_remain == '0)
        |=> (r_before == '0 && r_after == '0 && !r_ovf && r_out_eol))
        else $error("flush did not clear the line");

    // An insert into a full line is lost and remembered.
    a_drop_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && i_req_type == REQ_KEY && w_full
         && i_key_code != KEY_BACKSPACE && i_key_code != KEY_LEFT
         && i_key_code != KEY_RIGHT)
        |=> (r_ovf && $stable(r_before) && $stable(r_after)))
        else $error("insert into a full line was not dropped");

endmodule

>>> rtl/leb_cell.sv
module leb_cell #(
    parameter int CNT_W    = 6,
    parameter int CELL_IDX = 0
) (
    input  logic                i_clk,
    input  leb_pkg::t_cell_ctl  i_ctl,
    input  logic [CNT_W-1:0]    i_pos,
    input  logic [7:0]          i_left,
    input  logic [7:0]          i_right,
    output logic [7:0]          o_char
);
    import leb_pkg::*;

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(CELL_IDX);

    logic [7:0] r_char;
    logic [7:0] n_char;

    // An insert opens a slot at the position and pushes later cells right.
    // A remove closes the slot at the position and pulls later cells left.
    always_comb begin
        n_char = r_char;
        case (i_ctl.op)
            CELL_INSERT: begin
                if (MY_IDX == i_pos) begin
                    n_char = i_ctl.key;
                end else if (MY_IDX > i_pos) begin
                    n_char = i_left;
                end
            end
            CELL_REMOVE: begin
                if (MY_IDX >= i_pos) begin
                    n_char = i_right;
                end
            end
            default: begin
                n_char = r_char;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_char <= n_char;
    end

    assign o_char = r_char;

endmodule

>>> sim/line_edit_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the line editor, keeps its own copy of the line
// as two stacks around the cursor, and compares every output transfer with
// the oldest character still owed.
module line_edit_checker #(
    parameter int CAPACITY = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic       i_req_type,
    input  logic [7:0] i_key_code,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_out_char,
    input  logic       i_end_of_line,
    input  logic       i_dropped_input,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_chars_checked,
    output int         o_lines_checked,
    output int         o_dropped_lines
);
    import leb_pkg::*;

    typedef struct packed {
        logic [7:0] ch;
        logic       eol;
        logic       dropped;
    } t_line_char;

    // Characters left of the cursor (top nearest the cursor) and right of it.
    logic [7:0] left_stack  [CAPACITY];
    logic [7:0] right_stack [CAPACITY];
    int         left_depth;
    int         right_depth;
    logic       lost_insert;

    t_line_char owed_chars[$];
    t_line_char oldest;
    int         fail_count;
    int         pending;
    int         chars_checked;
    int         lines_checked;
    int         dropped_lines;

    assign o_fail_count    = fail_count;
    assign o_pending       = pending;
    assign o_chars_checked = chars_checked;
    assign o_lines_checked = lines_checked;
    assign o_dropped_lines = dropped_lines;

    // Apply one keystroke to the predicted line.
    task automatic edit_line(input logic [7:0] key);
        case (key)
            KEY_BACKSPACE: begin
                if (left_depth > 0)
                    left_depth--;
            end
            KEY_LEFT: begin
                if (left_depth > 0 && right_depth < CAPACITY) begin
                    left_depth--;
                    right_stack[right_depth] = left_stack[left_depth];
                    right_depth++;
                end
            end
            KEY_RIGHT: begin
                if (right_depth > 0 && left_depth < CAPACITY) begin
                    right_depth--;
                    left_stack[left_depth] = right_stack[right_depth];
                    left_depth++;
                end
            end
            default: begin
                if (left_depth + right_depth < CAPACITY) begin
                    left_stack[left_depth] = key;
                    left_depth++;
                end else begin
                    lost_insert = 1'b1;
                end
            end
        endcase
    endtask

    // Queue the whole line in order, then the closing newline, and clear it.
    task automatic emit_line();
        t_line_char owed;
        for (int i = 0; i < left_depth; i++) begin
            owed       = '{ch: left_stack[i], eol: 1'b0, dropped: lost_insert};
            owed_chars = {owed_chars, owed};
        end
        for (int i = right_depth; i > 0; i--) begin
            owed       = '{ch: right_stack[i-1], eol: 1'b0, dropped: lost_insert};
            owed_chars = {owed_chars, owed};
        end
        owed       = '{ch: NEWLINE_CHAR, eol: 1'b1, dropped: lost_insert};
        owed_chars = {owed_chars, owed};
        left_depth  = 0;
        right_depth = 0;
        lost_insert = 1'b0;
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    initial begin
        fail_count    = 0;
        pending       = 0;
        chars_checked = 0;
        lines_checked = 0;
        dropped_lines = 0;
        left_depth    = 0;
        right_depth   = 0;
        lost_insert   = 1'b0;
    end

    // Output transfers are checked before the input transfer of the same edge
    // is predicted, so the queue always holds the oldest character in front.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            left_depth  = 0;
            right_depth = 0;
            lost_insert = 1'b0;
            owed_chars.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (owed_chars.size() == 0) begin
                    $error("unexpected output transfer: char %0d, end_of_line %0b",
                           i_out_char, i_end_of_line);
                    fail_count++;
                end else begin
                    oldest = owed_chars.pop_front();
                    check_field("out_char", oldest.ch, i_out_char);
                    check_field("end_of_line", 8'(oldest.eol), 8'(i_end_of_line));
                    check_field("dropped_input", 8'(oldest.dropped), 8'(i_dropped_input));
                    chars_checked++;
                    if (oldest.eol) begin
                        lines_checked++;
                        if (oldest.dropped)
                            dropped_lines++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_req_type == REQ_FLUSH)
                    emit_line();
                else
                    edit_line(i_key_code);
            end
        end
        pending = owed_chars.size();
    end

endmodule

>>> sim/line_edit_gap_buffer_test.sv
`timescale 1ns / 1ps

// Drives keystrokes and end-of-line requests into the line editor with random
// gaps and output stalls, and gives the verdict from the checker's count.
module line_edit_gap_buffer_test;
    import leb_pkg::*;

    localparam int CAPACITY        = 32;
    localparam int RANDOM_ITEMS    = 290;
    localparam int PRESSURE_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 60;
    localparam int CYCLE_LIMIT     = 2_000_000;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic       i_req_type;
    logic [7:0] i_key_code;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [7:0] o_out_char;
    logic       o_end_of_line;
    logic       o_dropped_input;

    int fail_count;
    int pending;
    int chars_checked;
    int lines_checked;
    int dropped_lines;

    int items_sent;
    int cycle_count;
    bit no_gaps;
    bit pressure_req;
    bit pressure_done;

    line_edit_gap_buffer #(
        .CAPACITY(CAPACITY)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_key_code     (i_key_code),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_char     (o_out_char),
        .o_end_of_line  (o_end_of_line),
        .o_dropped_input(o_dropped_input)
    );

    line_edit_checker #(
        .CAPACITY(CAPACITY)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_key_code     (i_key_code),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_out_char     (o_out_char),
        .i_end_of_line  (o_end_of_line),
        .i_dropped_input(o_dropped_input),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_chars_checked(chars_checked),
        .o_lines_checked(lines_checked),
        .o_dropped_lines(dropped_lines)
    );

    // Clock with a 10 ns period.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Idle stretch length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Keystroke for a line; fill lines are mostly inserts so they overflow.
    function automatic logic [7:0] pick_key(input bit fill);
        int r;
        r = $urandom_range(0, 19);
        if (fill) begin
            if (r < 18)
                return 8'($urandom_range(0, 255));
            else if (r == 18)
                return KEY_LEFT;
            else
                return KEY_RIGHT;
        end
        if (r < 11)
            return 8'($urandom_range(0, 255));
        else if (r < 14)
            return KEY_BACKSPACE;
        else if (r < 17)
            return KEY_LEFT;
        else
            return KEY_RIGHT;
    endfunction

    // Offer one item from a falling edge and hold it until the transfer,
    // then idle for a random gap unless this stretch runs without gaps.
    task automatic send_item(input logic req, input logic [7:0] key);
        int gap;
        i_in_valid = 1'b1;
        i_req_type = req;
        i_key_code = key;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        items_sent++;
        @(negedge i_clk);
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid = 1'b0;
            i_req_type = 1'($urandom_range(0, 1));
            i_key_code = 8'($urandom_range(0, 255));
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Cycle limit on the whole run.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("line_edit_gap_buffer_test: done, errors");
                $finish;
            end
        end
    end

    // Receiver: random stalls, quiet stretches, and one long hold-off.
    initial begin
        int stall_left;
        int phase_left;
        bit quiet;
        i_out_ready   = 1'b0;
        pressure_done = 1'b0;
        stall_left    = 0;
        phase_left    = 0;
        quiet         = 1'b0;
        forever begin
            @(negedge i_clk);
            if (phase_left == 0) begin
                quiet      = ($urandom_range(0, 3) == 0);
                phase_left = $urandom_range(50, 200);
            end else begin
                phase_left--;
            end
            if (pressure_req && !pressure_done) begin
                i_out_ready = 1'b0;
                repeat (PRESSURE_CYCLES - 1) @(negedge i_clk);
                pressure_done = 1'b1;
            end else if (stall_left > 0) begin
                i_out_ready = 1'b0;
                stall_left--;
            end else begin
                i_out_ready = 1'b1;
                stall_left  = quiet ? 0 : pick_gap();
            end
        end
    end

    // Stimulus and verdict.
    initial begin
        int directed_items;
        int line_len;
        bit fill_line;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_req_type   = REQ_KEY;
        i_key_code   = 8'h00;
        items_sent   = 0;
        no_gaps      = 1'b0;
        pressure_req = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Empty line, and edits at both ends of an empty line.
        send_item(REQ_FLUSH, KEY_LEFT);
        send_item(REQ_KEY, KEY_BACKSPACE);
        send_item(REQ_KEY, KEY_LEFT);
        send_item(REQ_KEY, KEY_RIGHT);
        send_item(REQ_FLUSH, 8'h00);

        // Extreme bytes, an embedded newline and a space, with cursor moves,
        // a backspace in the middle and a right move past the end.
        send_item(REQ_KEY, 8'h00);
        send_item(REQ_KEY, 8'hFF);
        send_item(REQ_KEY, NEWLINE_CHAR);
        send_item(REQ_KEY, 8'h20);
        send_item(REQ_KEY, KEY_LEFT);
        send_item(REQ_KEY, KEY_LEFT);
        send_item(REQ_KEY, KEY_BACKSPACE);
        send_item(REQ_KEY, 8'hA5);
        send_item(REQ_KEY, KEY_RIGHT);
        send_item(REQ_KEY, KEY_RIGHT);
        send_item(REQ_KEY, KEY_RIGHT);
        send_item(REQ_KEY, KEY_LEFT);
        send_item(REQ_FLUSH, 8'hFF);

        // Cursor at the start with text after it: left and backspace do nothing.
        send_item(REQ_KEY, 8'h78);
        send_item(REQ_KEY, KEY_LEFT);
        send_item(REQ_KEY, KEY_LEFT);
        send_item(REQ_KEY, KEY_BACKSPACE);
        send_item(REQ_FLUSH, KEY_BACKSPACE);
        directed_items = items_sent;

        // Random lines: the receiver holds off for a long stretch at first,
        // so the block stalls its input while a line is being flushed.
        pressure_req = 1'b1;
        while (items_sent < directed_items + RANDOM_ITEMS) begin
            fill_line = ($urandom_range(0, 4) == 0);
            no_gaps   = ($urandom_range(0, 3) == 0);
            line_len  = fill_line ? $urandom_range(36, 48) : $urandom_range(0, 12);
            for (int k = 0; k < line_len; k++) begin
                // Now and then a line is cut short by an early flush.
                if (!fill_line && $urandom_range(0, 29) == 0)
                    send_item(REQ_FLUSH, 8'($urandom_range(0, 255)));
                send_item(REQ_KEY, pick_key(fill_line));
            end
            send_item(REQ_FLUSH, 8'($urandom_range(0, 255)));
        end
        i_in_valid = 1'b0;
        no_gaps    = 1'b0;

        // Drain every owed character, then let the block settle.
        while (pending != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Sent %0d keystroke and end-of-line transfers; checked %0d lines",
                 items_sent, lines_checked);
        $display("(%0d characters), %0d of them with inserts dropped on a full line.",
                 chars_checked, dropped_lines);
        if (fail_count == 0)
            $display("line_edit_gap_buffer_test: done, clean");
        else
            $display("line_edit_gap_buffer_test: done, errors");
        $finish;
    end

endmodule

>>> files.f
rtl/leb_pkg.sv
rtl/leb_cell.sv
rtl/line_edit_gap_buffer.sv
sim/line_edit_checker.sv
sim/line_edit_gap_buffer_test.sv
